// ===== hw/rtl/fdc_pkg.sv =====
// ----------------------------------------------------------------------------
// fdc_pkg
// types and constants shared by the floppy controller register block
// ----------------------------------------------------------------------------
package fdc_pkg;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    localparam logic [1:0] REG_STATUS = 2'd0;
    localparam logic [1:0] REG_TRACK  = 2'd1;
    localparam logic [1:0] REG_SECTOR = 2'd2;
    localparam logic [1:0] REG_DATA   = 2'd3;

    localparam logic [7:0] ST_BUSY = 8'h01;
    localparam logic [7:0] ST_DRQ  = 8'h02;
    localparam logic [7:0] ST_TRK0 = 8'h04;
    localparam logic [7:0] ST_RNF  = 8'h10;
    localparam logic [7:0] ST_HEAD = 8'h20;
    localparam logic [7:0] ST_WP   = 8'h40;
    localparam logic [7:0] ST_NRDY = 8'h80;

    localparam logic [3:0] OP_RESTORE  = 4'h0;
    localparam logic [3:0] OP_SEEK     = 4'h1;
    localparam logic [3:0] OP_STEP     = 4'h2;
    localparam logic [3:0] OP_STEP_U   = 4'h3;
    localparam logic [3:0] OP_STEPI    = 4'h4;
    localparam logic [3:0] OP_STEPI_U  = 4'h5;
    localparam logic [3:0] OP_STEPO    = 4'h6;
    localparam logic [3:0] OP_STEPO_U  = 4'h7;
    localparam logic [3:0] OP_RDSEC    = 4'h8;
    localparam logic [3:0] OP_RDSEC_M  = 4'h9;
    localparam logic [3:0] OP_WRSEC    = 4'hA;
    localparam logic [3:0] OP_WRSEC_M  = 4'hB;
    localparam logic [3:0] OP_RDADDR   = 4'hC;
    localparam logic [3:0] OP_FORCE    = 4'hD;
    localparam logic [3:0] OP_RDTRK    = 4'hE;
    localparam logic [3:0] OP_WRTRK    = 4'hF;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] reg_addr;
        logic [7:0] wdata;
        logic [7:0] disk_byte;
        logic       drive_ready;
        logic       write_protect;
        logic       seek_error;
        logic       record_missing;
        logic       track_write_ok;
    } t_in;

    typedef struct packed {
        logic [7:0]  rdata;
        logic        irq;
        logic        drq;
        logic        medium_read;
        logic        medium_write;
        logic [14:0] medium_pos;
        logic [3:0]  active_command;
    } t_out;

    typedef struct packed {
        logic [7:0]  status;
        logic [7:0]  command;
        logic [7:0]  track;
        logic [7:0]  sector;
        logic [7:0]  data;
        logic [14:0] count;
        logic        dir_out;
        logic        drq;
        logic [5:0]  srd_cnt;
        logic [3:0]  idx_cnt;
        logic        irq;
    } t_state;

endpackage

// ===== hw/rtl/fdc_core.sv =====
// ----------------------------------------------------------------------------
// fdc_core
// next-state and result logic for one bus access
// ----------------------------------------------------------------------------
module fdc_core (
    input  fdc_pkg::t_in    i_item,
    input  fdc_pkg::t_state i_st,
    input  logic [10:0]     i_bps,
    output fdc_pkg::t_state o_st,
    output fdc_pkg::t_out   o_res
);

    function automatic fdc_pkg::t_state run_cmd(
        input fdc_pkg::t_state s_in, input logic [7:0] c, input logic rdy,
        input logic wp, input logic serr, input logic rnf, input logic twok,
        input logic [10:0] bps);
        fdc_pkg::t_state s;
        logic [3:0] op;
        logic [7:0] tgt;
        logic       do_seek;
        s = s_in;
        op = c[7:4];
        do_seek = 1'b0;
        tgt = 8'd0;
        if (!(s.status[0] && op != fdc_pkg::OP_FORCE)) begin
            s.command = c;
            s.count = 15'd0;
            case (op)
                fdc_pkg::OP_RESTORE: begin
                    do_seek = 1'b1;
                    tgt = 8'd0;
                end
                fdc_pkg::OP_SEEK: begin
                    do_seek = 1'b1;
                    tgt = s.data;
                end
                fdc_pkg::OP_STEP_U: begin
                    do_seek = 1'b1;
                    tgt = s.dir_out ? s.track - 8'd1 : s.track + 8'd1;
                end
                fdc_pkg::OP_STEP: begin
                    s.status = 8'h00;
                    s.irq = 1'b1;
                end
                fdc_pkg::OP_STEPI_U: begin
                    s.dir_out = 1'b0;
                    do_seek = 1'b1;
                    tgt = s.track + 8'd1;
                end
                fdc_pkg::OP_STEPI: begin
                    s.status = 8'h00;
                    s.dir_out = 1'b0;
                    s.irq = 1'b1;
                end
                fdc_pkg::OP_STEPO_U: begin
                    s.dir_out = 1'b1;
                    do_seek = 1'b1;
                    tgt = (s.track != 8'd0) ? s.track - 8'd1 : 8'd0;
                end
                fdc_pkg::OP_STEPO: begin
                    s.status = 8'h00;
                    s.dir_out = 1'b1;
                    s.irq = 1'b1;
                end
                fdc_pkg::OP_RDSEC, fdc_pkg::OP_RDSEC_M: begin
                    s.srd_cnt = 6'd0;
                    if (rnf) begin
                        s.status = fdc_pkg::ST_RNF;
                        s.irq = 1'b1;
                    end else begin
                        s.count = {4'd0, bps};
                        s.drq = 1'b1;
                        s.status = fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ;
                    end
                end
                fdc_pkg::OP_RDTRK: begin
                    s.count = {bps, 4'd0};
                    s.drq = 1'b1;
                    s.status = fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ;
                end
                fdc_pkg::OP_WRSEC, fdc_pkg::OP_WRSEC_M: begin
                    if (wp) begin
                        s.status = fdc_pkg::ST_WP;
                        s.irq = 1'b1;
                    end else if (rnf) begin
                        s.status = fdc_pkg::ST_RNF;
                        s.irq = 1'b1;
                    end else begin
                        s.count = {4'd0, bps};
                        s.drq = 1'b1;
                        s.status = fdc_pkg::ST_DRQ;
                    end
                end
                fdc_pkg::OP_WRTRK: begin
                    if (wp) begin
                        s.status = fdc_pkg::ST_WP;
                        s.irq = 1'b1;
                    end else if (twok) begin
                        s.count = 15'd256;
                        s.drq = 1'b1;
                        s.status = fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ;
                    end else begin
                        s.drq = 1'b0;
                        s.status = fdc_pkg::ST_HEAD;
                        s.irq = 1'b1;
                    end
                end
                fdc_pkg::OP_RDADDR: begin
                    if (rdy) begin
                        s.count = 15'd6;
                        s.drq = 1'b1;
                        s.status = fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ;
                    end else begin
                        s.status = fdc_pkg::ST_RNF;
                        s.irq = 1'b1;
                    end
                end
                default: begin
                    s.drq = 1'b0;
                    s.status = s.status & ~(fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ);
                    s.irq = 1'b1;
                end
            endcase
            if (do_seek) begin
                s.status = fdc_pkg::ST_HEAD;
                if (serr) s.status = s.status | fdc_pkg::ST_RNF;
                else s.track = tgt;
                if (s.track == 8'd0) s.status = s.status | fdc_pkg::ST_TRK0;
                s.irq = 1'b1;
                if (op == fdc_pkg::OP_STEP_U) s.status = 8'h00;
                // restore forces track zero even on a seek error
                if (op == fdc_pkg::OP_RESTORE) s.track = 8'd0;
            end
            if (!c[7]) begin
                if (rdy) begin
                    s.idx_cnt = s.idx_cnt + 4'd1;
                    s.status = s.status | fdc_pkg::ST_HEAD;
                    if (wp) s.status = s.status | fdc_pkg::ST_WP;
                    if (s.idx_cnt == 4'd0) s.status = s.status | fdc_pkg::ST_DRQ;
                end else begin
                    s.track = 8'd1;
                    s.status = fdc_pkg::ST_NRDY;
                end
            end
        end
        run_cmd = s;
    endfunction

    function automatic fdc_pkg::t_state after_data(
        input fdc_pkg::t_state s_in, input logic [3:0] mop, input logic rnf,
        input logic [10:0] bps);
        fdc_pkg::t_state s;
        s = s_in;
        if (s.count == 15'd0 && s.command[7:4] == mop) begin
            s.sector = s.sector + 8'd1;
            if (rnf) s.status = s.status | fdc_pkg::ST_RNF;
            else s.count = {4'd0, bps};
        end
        if (s.drq && s.count == 15'd0) begin
            s.drq = 1'b0;
            s.status = s.status & ~(fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ);
            s.irq = 1'b1;
        end
        after_data = s;
    endfunction

    fdc_pkg::t_state s;
    fdc_pkg::t_state z;
    fdc_pkg::t_out   r;

    always_comb begin
        s = i_st;
        r = '0;
        z = '0;
        z.track = i_st.track;
        z.sector = i_st.sector;
        z.data = i_st.data;
        case (i_item.cmd)
            fdc_pkg::CMD_RESET: begin
                s = run_cmd(z, 8'h00, i_item.drive_ready, i_item.write_protect,
                    i_item.seek_error, i_item.record_missing, i_item.track_write_ok, i_bps);
            end
            fdc_pkg::CMD_READ: begin
                case (i_item.reg_addr)
                    fdc_pkg::REG_STATUS: begin
                        s.irq = 1'b0;
                        if (s.command[7:5] == 3'b100) begin
                            s.srd_cnt = s.srd_cnt + 6'd1;
                            if (s.srd_cnt == 6'd32) begin
                                s.drq = 1'b0;
                                s.status = s.status & ~(fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ);
                            end
                        end
                        s.idx_cnt = s.idx_cnt + 4'd1;
                        if (s.idx_cnt == 4'd0) s.status = s.status & ~fdc_pkg::ST_NRDY;
                        r.rdata = s.status;
                        if (!s.status[7] && s.idx_cnt == 4'd0 && !s.command[7])
                            r.rdata = r.rdata | fdc_pkg::ST_DRQ;
                    end
                    fdc_pkg::REG_TRACK:  r.rdata = s.track;
                    fdc_pkg::REG_SECTOR: r.rdata = s.sector;
                    default: begin
                        s.srd_cnt = 6'd0;
                        if (s.count != 15'd0) begin
                            s.data = i_item.disk_byte;
                            r.medium_read = 1'b1;
                            r.medium_pos = s.count;
                            s.count = s.count - 15'd1;
                        end
                        s = after_data(s, fdc_pkg::OP_RDSEC_M, i_item.record_missing, i_bps);
                        r.rdata = s.data;
                    end
                endcase
            end
            fdc_pkg::CMD_WRITE: begin
                case (i_item.reg_addr)
                    fdc_pkg::REG_STATUS: begin
                        s.irq = 1'b0;
                        s = run_cmd(s, i_item.wdata, i_item.drive_ready,
                            i_item.write_protect, i_item.seek_error,
                            i_item.record_missing, i_item.track_write_ok, i_bps);
                    end
                    fdc_pkg::REG_TRACK:  s.track = i_item.wdata;
                    fdc_pkg::REG_SECTOR: s.sector = i_item.wdata;
                    default: begin
                        s.data = i_item.wdata;
                        if (s.count != 15'd0) begin
                            r.medium_write = 1'b1;
                            r.medium_pos = s.count;
                            s.count = s.count - 15'd1;
                        end
                        s = after_data(s, fdc_pkg::OP_WRSEC_M, i_item.record_missing, i_bps);
                    end
                endcase
            end
            default: ;
        endcase
        r.irq = s.irq;
        r.drq = s.drq;
        r.active_command = s.command[7:4];
    end

    assign o_st = s;
    assign o_res = r;

endmodule

// ===== hw/rtl/floppy_controller_registers.sv =====
// ----------------------------------------------------------------------------
// floppy_controller_registers
// register file of a simplified floppy controller, one bus access per beat
//
// channel | direction | handshake            | payload
// in      | input     | i_in_valid/o_in_ready | i_in (fdc_pkg::t_in)
// out     | output    | o_out_valid/i_out_ready | o_out (fdc_pkg::t_out)
// cfg     | input     | i_cfg_we              | i_cfg_wdata (bytes per sector)
//
// one beat per cycle while not stalled; the access is decoded combinationally
// into the output register. input is taken whenever the output register is
// empty or being drained. synchronous reset leaves the post-restore state.
// ----------------------------------------------------------------------------
module floppy_controller_registers (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fdc_pkg::t_in    i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output fdc_pkg::t_out   o_out,
    input  logic            i_cfg_we,
    input  logic [10:0]     i_cfg_wdata
);

    fdc_pkg::t_state r_st;
    fdc_pkg::t_state n_st;
    fdc_pkg::t_out   n_res;
    fdc_pkg::t_out   r_out;
    logic            r_out_valid;
    logic [10:0]     r_bps;
    logic            w_acc;

    fdc_core u_core (
        .i_item (i_in),
        .i_st   (r_st),
        .i_bps  (r_bps),
        .o_st   (n_st),
        .o_res  (n_res)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_acc = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '{status: fdc_pkg::ST_HEAD | fdc_pkg::ST_TRK0, idx_cnt: 4'd1,
                      irq: 1'b1, default: '0};
            r_bps <= 11'd256;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_bps <= i_cfg_wdata;
            if (w_acc) begin
                r_st <= n_st;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) r_out <= n_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

endmodule
